>>> rtl/core/iir4_pkg.sv
// ----------------------------------------------------------------------------
// iir4_pkg
// Shared types, constants and the microcode table of the fourth-order
// transposed direct form II filter.
// ----------------------------------------------------------------------------
package iir4_pkg;

    localparam int SAMPLE_W = 32;   // Q16.16 samples
    localparam int COEF_W   = 32;   // Q4.28 coefficients
    localparam int PROD_W   = 64;   // full product, 44 fraction bits
    localparam int TERM_W   = 52;   // product rounded to 32 fraction bits
    localparam int DELAY_W  = 48;   // Q16.32 delay elements
    localparam int ACC_W    = 54;   // term + delay - term, never overflows
    localparam int CFG_W    = 64;
    localparam int N_REGS   = 7;
    localparam int REG_IDX_W = 3;
    localparam int N_DELAY  = 4;
    localparam int ZSEL_W   = 2;
    localparam int PC_W     = 4;

    localparam logic [CFG_W-1:0] B0_B1_RESET = 64'h1000_0000_0000_0000;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_B0_B1 = 3'd0,
        REG_B2_B3 = 3'd1,
        REG_B4_A1 = 3'd2,
        REG_A2_A3 = 3'd3,
        REG_A4    = 3'd4,
        REG_Z0_Z1 = 3'd5,
        REG_Z2_Z3 = 3'd6
    } t_reg_idx;

    // multiplier coefficient select
    typedef enum logic [3:0] {
        C_B0, C_B1, C_B2, C_B3, C_B4,
        C_A1, C_A2, C_A3, C_A4,
        C_Z0, C_Z1, C_Z2, C_Z3
    } t_coef_sel;

    // multiplier data operand
    typedef enum logic {
        SRC_X,
        SRC_Y
    } t_src;

    typedef enum logic [1:0] {
        ACC_HOLD,       // accumulator keeps its value
        ACC_TERM,       // acc = term
        ACC_TERM_Z,     // acc = term + z[zsel]
        ACC_SUB         // acc = acc - term
    } t_acc_op;

    typedef enum logic [1:0] {
        BR_NEXT,        // pc + 1
        BR_NWS,         // jump to target unless the word opens a window
        BR_END          // last step of the program
    } t_br;

    typedef struct packed {
        t_coef_sel          coef;
        t_src               src;
        t_acc_op            acc_op;
        logic [ZSEL_W-1:0]  zsel;
        logic               wr_z;   // z[zsel] <= sat48(next acc)
        logic               wr_y;   // y <= sat32(round(acc))
        t_br                br;
        logic [PC_W-1:0]    target;
    } t_ctl;

    localparam t_ctl CTL_IDLE = '{C_B0, SRC_X, ACC_HOLD, 2'd0, 1'b0, 1'b0, BR_NEXT, 4'd0};

    // microcode rom
    function automatic t_ctl ucode(input logic [PC_W-1:0] pc);
        t_ctl c;
        c = CTL_IDLE;
        case (pc)
            // dispatch: b0*x, skip the state load unless the window starts here
            4'd0:  c = '{C_B0, SRC_X, ACC_HOLD,   2'd0, 1'b0, 1'b0, BR_NWS,  4'd6};
            // state load z[i] = zi[i] * x
            4'd1:  c = '{C_Z0, SRC_X, ACC_HOLD,   2'd0, 1'b0, 1'b0, BR_NEXT, 4'd0};
            4'd2:  c = '{C_Z1, SRC_X, ACC_TERM,   2'd0, 1'b1, 1'b0, BR_NEXT, 4'd0};
            4'd3:  c = '{C_Z2, SRC_X, ACC_TERM,   2'd1, 1'b1, 1'b0, BR_NEXT, 4'd0};
            4'd4:  c = '{C_Z3, SRC_X, ACC_TERM,   2'd2, 1'b1, 1'b0, BR_NEXT, 4'd0};
            4'd5:  c = '{C_B0, SRC_X, ACC_TERM,   2'd3, 1'b1, 1'b0, BR_NEXT, 4'd0};
            // output and delay update
            4'd6:  c = '{C_B1, SRC_X, ACC_TERM_Z, 2'd0, 1'b0, 1'b0, BR_NEXT, 4'd0};
            4'd7:  c = '{C_A1, SRC_X, ACC_TERM_Z, 2'd1, 1'b0, 1'b1, BR_NEXT, 4'd0};
            4'd8:  c = '{C_A1, SRC_Y, ACC_HOLD,   2'd0, 1'b0, 1'b0, BR_NEXT, 4'd0};
            4'd9:  c = '{C_B2, SRC_X, ACC_SUB,    2'd0, 1'b1, 1'b0, BR_NEXT, 4'd0};
            4'd10: c = '{C_A2, SRC_Y, ACC_TERM_Z, 2'd2, 1'b0, 1'b0, BR_NEXT, 4'd0};
            4'd11: c = '{C_B3, SRC_X, ACC_SUB,    2'd1, 1'b1, 1'b0, BR_NEXT, 4'd0};
            4'd12: c = '{C_A3, SRC_Y, ACC_TERM_Z, 2'd3, 1'b0, 1'b0, BR_NEXT, 4'd0};
            4'd13: c = '{C_B4, SRC_X, ACC_SUB,    2'd2, 1'b1, 1'b0, BR_NEXT, 4'd0};
            4'd14: c = '{C_A4, SRC_Y, ACC_TERM,   2'd0, 1'b0, 1'b0, BR_NEXT, 4'd0};
            4'd15: c = '{C_A4, SRC_Y, ACC_SUB,    2'd3, 1'b1, 1'b0, BR_END,  4'd0};
            default: c = CTL_IDLE;
        endcase
        return c;
    endfunction

    // clamp the accumulator to the delay range
    function automatic logic signed [DELAY_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
        logic signed [DELAY_W-1:0] r;
        if (v[ACC_W-1:DELAY_W-1] == '0 || v[ACC_W-1:DELAY_W-1] == '1) begin
            r = v[DELAY_W-1:0];
        end else if (v[ACC_W-1]) begin
            r = {1'b1, {(DELAY_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(DELAY_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

>>> rtl/core/iir4_dpath.sv
// ----------------------------------------------------------------------------
// iir4_dpath
// Multiply-accumulate datapath driven by one control word per cycle: one
// registered 32x32 multiplier, rounding, accumulator, delay line, output.
// ----------------------------------------------------------------------------
module iir4_dpath
    import iir4_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_ctl                         i_ctl,
    input  logic signed [COEF_W-1:0]     i_coef,
    input  logic signed [SAMPLE_W-1:0]   i_x,
    output logic signed [SAMPLE_W-1:0]   o_y
);

    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    n_acc;
    logic signed [DELAY_W-1:0]  r_z [N_DELAY];
    logic signed [SAMPLE_W-1:0] r_y;
    logic signed [SAMPLE_W-1:0] n_y;

    logic signed [SAMPLE_W-1:0] w_opnd;
    logic signed [PROD_W-1:0]   w_rnd;
    logic signed [TERM_W-1:0]   w_term;
    logic signed [ACC_W-1:0]    w_term_x;
    logic signed [ACC_W-1:0]    w_z_x;
    logic signed [ACC_W-1:0]    w_ysum;
    logic signed [ACC_W-17:0]   w_ysh;

    assign w_opnd = (i_ctl.src == SRC_Y) ? r_y : i_x;

    // round half up to 32 fraction bits
    assign w_rnd    = r_prod + PROD_W'(2048);
    assign w_term   = w_rnd[PROD_W-1:12];
    assign w_term_x = ACC_W'(w_term);
    assign w_z_x    = ACC_W'(r_z[i_ctl.zsel]);

    always_comb begin
        case (i_ctl.acc_op)
            ACC_TERM:   n_acc = w_term_x;
            ACC_TERM_Z: n_acc = w_term_x + w_z_x;
            ACC_SUB:    n_acc = r_acc - w_term_x;
            default:    n_acc = r_acc;
        endcase
    end

    // output: round to 16 fraction bits, then saturate
    assign w_ysum = r_acc + ACC_W'(32768);
    assign w_ysh  = w_ysum[ACC_W-1:16];

    always_comb begin
        if (w_ysh[ACC_W-17:SAMPLE_W-1] == '0 || w_ysh[ACC_W-17:SAMPLE_W-1] == '1) begin
            n_y = w_ysh[SAMPLE_W-1:0];
        end else if (w_ysh[ACC_W-17]) begin
            n_y = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            n_y = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_coef * w_opnd;
        r_acc  <= n_acc;
        if (i_ctl.wr_y) begin
            r_y <= n_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_DELAY; i++) begin
                r_z[i] <= '0;
            end
        end else if (i_ctl.wr_z) begin
            r_z[i_ctl.zsel] <= sat48(n_acc);
        end
    end

    assign o_y = r_y;

    property p_wr_needs_acc;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_ctl.wr_z |-> (i_ctl.acc_op != ACC_HOLD);
    endproperty
    a_wr_needs_acc: assert property (p_wr_needs_acc)
        else $error("delay write without accumulator update");

    property p_y_not_with_z;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_ctl.wr_y |-> !i_ctl.wr_z;
    endproperty
    a_y_not_with_z: assert property (p_y_not_with_z)
        else $error("output and delay written in one step");

    property p_y_holds;
        @(posedge i_clk) disable iff (!i_rst_n)
            !$past(i_ctl.wr_y) |-> $stable(r_y);
    endproperty
    a_y_holds: assert property (p_y_holds)
        else $error("output register changed without a write");

endmodule

>>> rtl/core/iir_order4_filter.sv
// ----------------------------------------------------------------------------
// iir_order4_filter
// Fourth-order IIR filter, transposed direct form II, run by a microcoded
// sequencer over one shared multiply-accumulate datapath.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  -------   ---------  ----------------------  --------------------------------
//  input     in         i_valid / o_stall       i_sample, i_window_start
//  output    out        o_valid / i_stall       o_filtered
//  config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  a word runs the dispatch step, the state load when it starts a window,
//  and the output and delay update, then the output register; the single
//  multiplier forms one product per step, nine or thirteen products per word
//  the next input word is taken the cycle after the program ends, even while
//  the result still waits in the output register
//  a stalled output holds the program on its last step until the slot frees
//  synchronous active-low reset clears the delays, coefficients to their
//  defaults (b0 = 1.0) and all control state
//
module iir_order4_filter
    import iir4_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_W-1:0]    i_sample,
    input  logic                          i_window_start,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_W-1:0]    o_filtered,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [REG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data
);

    // coefficient and initial-state registers
    logic [CFG_W-1:0]            r_cfg [N_REGS];

    // sequencer
    logic                        r_busy;
    logic [PC_W-1:0]             r_pc;
    logic [PC_W-1:0]             n_pc;
    logic signed [SAMPLE_W-1:0]  r_x;
    logic                        r_ws;
    t_ctl                        w_rom;
    t_ctl                        w_ctl;
    logic                        w_accept;
    logic                        w_end;
    logic                        w_hold;
    logic                        w_done;

    // output register
    logic                        r_out_valid;
    logic signed [SAMPLE_W-1:0]  r_filtered;
    logic signed [SAMPLE_W-1:0]  w_y;
    logic signed [COEF_W-1:0]    w_coef;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_busy;
    assign w_accept    = i_valid && !r_busy;

    // config writes; unknown indexes are dropped, a4 keeps its low half only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_REGS; i++) begin
                r_cfg[i] <= (i == REG_B0_B1) ? B0_B1_RESET : '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_B0_B1, REG_B2_B3, REG_B4_A1, REG_A2_A3, REG_Z0_Z1, REG_Z2_Z3: begin
                    r_cfg[i_cfg_index] <= i_cfg_data;
                end
                REG_A4: begin
                    r_cfg[REG_A4] <= {32'd0, i_cfg_data[31:0]};
                end
                default: begin
                end
            endcase
        end
    end

    // microcode fetch; idle and held steps issue no writes
    assign w_rom  = ucode(r_pc);
    assign w_end  = r_busy && (w_rom.br == BR_END);
    assign w_hold = w_end && r_out_valid && i_stall;
    assign w_done = w_end && !w_hold;

    // a held last step keeps recomputing its own product so the pending
    // term survives the stall, but touches no accumulator or register
    always_comb begin
        w_ctl = CTL_IDLE;
        if (r_busy) begin
            w_ctl = w_rom;
            if (w_hold) begin
                w_ctl.acc_op = ACC_HOLD;
                w_ctl.wr_z   = 1'b0;
                w_ctl.wr_y   = 1'b0;
            end
        end
    end

    // next step: sequential, or a jump past the state load
    always_comb begin
        case (w_rom.br)
            BR_NWS:  n_pc = r_ws ? r_pc + 1'b1 : w_rom.target;
            default: n_pc = r_pc + 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
            r_pc   <= '0;
        end else if (w_done) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else if (r_busy && !w_hold) begin
            r_pc   <= n_pc;
        end
    end

    // input word is held for the whole program
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x  <= i_sample;
            r_ws <= i_window_start;
        end
    end

    // coefficient mux for the shared multiplier
    always_comb begin
        unique case (w_ctl.coef)
            C_B0:    w_coef = r_cfg[REG_B0_B1][63:32];
            C_B1:    w_coef = r_cfg[REG_B0_B1][31:0];
            C_B2:    w_coef = r_cfg[REG_B2_B3][63:32];
            C_B3:    w_coef = r_cfg[REG_B2_B3][31:0];
            C_B4:    w_coef = r_cfg[REG_B4_A1][63:32];
            C_A1:    w_coef = r_cfg[REG_B4_A1][31:0];
            C_A2:    w_coef = r_cfg[REG_A2_A3][63:32];
            C_A3:    w_coef = r_cfg[REG_A2_A3][31:0];
            C_A4:    w_coef = r_cfg[REG_A4][31:0];
            C_Z0:    w_coef = r_cfg[REG_Z0_Z1][63:32];
            C_Z1:    w_coef = r_cfg[REG_Z0_Z1][31:0];
            C_Z2:    w_coef = r_cfg[REG_Z2_Z3][63:32];
            C_Z3:    w_coef = r_cfg[REG_Z2_Z3][31:0];
            default: w_coef = '0;
        endcase
    end

    iir4_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_coef  (w_coef),
        .i_x     (r_x),
        .o_y     (w_y)
    );

    // output register decouples the sink from the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_filtered <= w_y;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_filtered = r_filtered;

    property p_accept_starts;
        @(posedge i_clk) disable iff (!i_rst_n)
            w_accept |=> (r_busy && r_pc == '0);
    endproperty
    a_accept_starts: assert property (p_accept_starts)
        else $error("accepted word did not start the program");

    property p_result_from_end;
        @(posedge i_clk) disable iff (!i_rst_n)
            $rose(o_valid) |-> $past(r_busy) && $past(w_rom.br == BR_END);
    endproperty
    a_result_from_end: assert property (p_result_from_end)
        else $error("result raised outside the last step");

    property p_hold_keeps_pc;
        @(posedge i_clk) disable iff (!i_rst_n)
            w_hold |=> (r_busy && $stable(r_pc));
    endproperty
    a_hold_keeps_pc: assert property (p_hold_keeps_pc)
        else $error("program moved while output stalled");

    property p_no_overwrite;
        @(posedge i_clk) disable iff (!i_rst_n)
            (o_valid && i_stall) |=> (o_valid && $stable(o_filtered));
    endproperty
    a_no_overwrite: assert property (p_no_overwrite)
        else $error("pending result lost");

endmodule
